// ----- sv/mtp_pkg.sv -----
// Shared types, codes and helpers of the MIDI track event parser.
package mtp_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // Status bytes
  localparam logic [7:0] ST_META   = 8'hFF;
  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;

  // High nibbles of channel statuses
  localparam logic [3:0] HI_CHAN_BASE = 4'h8;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHANPRESS = 4'hD;
  localparam logic [3:0] HI_BEND      = 4'hE;

  // Meta event types
  localparam logic [7:0] META_TEXT       = 8'h01;
  localparam logic [7:0] META_COPYRIGHT  = 8'h02;
  localparam logic [7:0] META_NAME       = 8'h03;
  localparam logic [7:0] META_INSTRUMENT = 8'h04;
  localparam logic [7:0] META_CUE        = 8'h07;
  localparam logic [7:0] META_EOT        = 8'h2F;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [7:0] META_TIMESIG    = 8'h58;

  localparam logic [27:0] TEMPO_LEN   = 28'd3;
  localparam logic [27:0] TIMESIG_LEN = 28'd4;
  localparam logic [13:0] BEND_CENTRE = 14'd8192;

  typedef enum logic [3:0] {
    K_NOTEOFF, K_NOTEON, K_POLYPRESS, K_CC, K_PROGRAM, K_CHANPRESS, K_BEND,
    K_TEMPO, K_TIMESIG, K_NAME, K_EOT, K_TEXT, K_UNKNOWN, K_SYSEX,
    K_PAYLOAD, K_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    E_TRUNC, E_NO_RUNNING, E_BAD_STATUS, E_TEMPO_LEN, E_TIMESIG_LEN, E_LONG_VLQ
  } err_t;

  // One result without its tick
  typedef struct packed {
    kind_t              kind;
    logic [3:0]         channel;
    logic [7:0]         data_first;
    logic [7:0]         data_second;
    logic signed [13:0] bend_value;
    logic [31:0]        word_value;
    logic               payload_last;
  } res_t;

  // Everything one input byte causes: an optional result, then an optional error
  typedef struct packed {
    logic        has_res;
    logic        has_err;
    err_t        err_code;
    logic [31:0] tick;
    res_t        res;
  } rec_t;

  function automatic kind_t meta_class(input logic [7:0] t);
    kind_t k;
    unique case (t) inside
      META_TEMPO:                                 k = K_TEMPO;
      META_TIMESIG:                               k = K_TIMESIG;
      META_NAME:                                  k = K_NAME;
      META_EOT:                                   k = K_EOT;
      META_TEXT, META_COPYRIGHT, [META_INSTRUMENT:META_CUE]: k = K_TEXT;
      default:                                    k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/mtp_in_if.sv -----
// Input byte channel of the MIDI track event parser.
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, in_byte, chunk_end, input ready);
  modport sink   (input valid, in_byte, chunk_end, output ready);
endinterface

// ----- sv/mtp_out_if.sv -----
// Result channel of the MIDI track event parser.
interface mtp_out_if;
  import mtp_pkg::*;

  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [31:0]        tick;
  logic [3:0]         channel;
  logic [7:0]         data_first;
  logic [7:0]         data_second;
  logic signed [13:0] bend_value;
  logic [31:0]        word_value;
  logic               payload_last;
  err_t               error_code;
  logic               run_last;

  modport source (output valid, kind, tick, channel, data_first, data_second, bend_value,
                  word_value, payload_last, error_code, run_last, input ready);
  modport sink   (input valid, kind, tick, channel, data_first, data_second, bend_value,
                  word_value, payload_last, error_code, run_last, output ready);
endinterface

// ----- sv/mtp_front.sv -----
// Parser front end: takes track bytes, keeps parse state, builds one record per byte.
module mtp_front #(
  parameter int TICK_BITS = mtp_pkg::TICK_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mtp_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output mtp_pkg::rec_t rec
);
  import mtp_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_XLEN, PH_BODY,
    PH_DISCARD
  } phase_t;

  phase_t                 phase, phase_next;
  logic [TICK_BITS-1:0]   abs_tick, abs_tick_next, tick_upd;
  logic [27:0]            vlq_acc, vlq_acc_next;
  logic [2:0]             vlq_cnt, vlq_cnt_next;
  logic [7:0]             run_status, run_status_next;
  logic [7:0]             cur_status, cur_status_next;
  logic [7:0]             held, held_next;
  logic [7:0]             meta_kind, meta_kind_next;
  logic [27:0]            bytes_rem, bytes_rem_next;
  logic [31:0]            pay_shift, pay_shift_next;

  logic [7:0]             b;
  logic                   take;
  logic [27:0]            vlq_new;
  logic [2:0]             vlq_cnt_inc;
  logic                   vlq_long;
  logic [TICK_BITS+31:0]  tick_ext;
  logic                   do_data;
  logic [7:0]             data_status;
  logic                   emit_ch;
  logic [7:0]             ch_status, ch_d1, ch_d2;
  logic                   do_body_start;
  logic                   is_sysex;
  kind_t                  mk;
  kind_t                  body_kind;
  logic [27:0]            rem_dec;
  logic [31:0]            shift_in;
  logic [13:0]            bend_raw;

  assign b           = in_ch.in_byte;
  assign take        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign push        = take && (rec.has_res || rec.has_err);

  assign vlq_new     = {vlq_acc[20:0], b[6:0]};
  assign vlq_cnt_inc = vlq_cnt + 3'd1;
  assign vlq_long    = b[7] && (vlq_cnt_inc >= 3'd4);
  assign mk          = meta_class(meta_kind);
  assign body_kind   = (cur_status == ST_META) ? mk : K_SYSEX;
  assign rem_dec     = bytes_rem - 28'd1;
  assign shift_in    = {pay_shift[23:0], b};
  assign tick_ext    = {32'd0, tick_upd};

  always_comb begin
    phase_next      = phase;
    abs_tick_next   = abs_tick;
    vlq_acc_next    = vlq_acc;
    vlq_cnt_next    = vlq_cnt;
    run_status_next = run_status;
    cur_status_next = cur_status;
    held_next       = held;
    meta_kind_next  = meta_kind;
    bytes_rem_next  = bytes_rem;
    pay_shift_next  = pay_shift;
    tick_upd        = abs_tick;
    rec             = '0;
    do_data         = 1'b0;
    data_status     = cur_status;
    emit_ch         = 1'b0;
    ch_status       = cur_status;
    ch_d1           = b;
    ch_d2           = '0;
    do_body_start   = 1'b0;
    is_sysex        = 1'b0;
    bend_raw        = '0;

    unique case (phase)
      PH_DELTA: begin
        vlq_acc_next = vlq_new;
        vlq_cnt_next = vlq_cnt_inc;
        if (vlq_long) begin
          rec.has_err  = 1'b1;
          rec.err_code = E_LONG_VLQ;
        end else if (!b[7]) begin
          tick_upd      = abs_tick + TICK_BITS'(vlq_new);
          abs_tick_next = tick_upd;
          vlq_acc_next  = '0;
          vlq_cnt_next  = '0;
          phase_next    = PH_STATUS;
          rec.has_err   = in_ch.chunk_end;
        end else begin
          rec.has_err = in_ch.chunk_end;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          cur_status_next = b;
          if (b < ST_SYSEX) begin
            run_status_next = b;
            phase_next      = PH_DATA1;
            rec.has_err     = in_ch.chunk_end;
          end else if (b == ST_META) begin
            phase_next  = PH_MTYPE;
            rec.has_err = in_ch.chunk_end;
          end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            vlq_acc_next = '0;
            vlq_cnt_next = '0;
            phase_next   = PH_XLEN;
            rec.has_err  = in_ch.chunk_end;
          end else begin
            rec.has_err  = 1'b1;
            rec.err_code = E_BAD_STATUS;
          end
        end else if (run_status == '0) begin
          rec.has_err  = 1'b1;
          rec.err_code = E_NO_RUNNING;
        end else begin
          cur_status_next = run_status;
          data_status     = run_status;
          do_data         = 1'b1;
        end
      end
      PH_DATA1: begin
        do_data = 1'b1;
      end
      PH_DATA2: begin
        emit_ch = 1'b1;
        ch_d1   = held;
        ch_d2   = b;
      end
      PH_MTYPE: begin
        meta_kind_next = b;
        vlq_acc_next   = '0;
        vlq_cnt_next   = '0;
        phase_next     = PH_MLEN;
        rec.has_err    = in_ch.chunk_end;
      end
      PH_MLEN, PH_XLEN: begin
        vlq_acc_next = vlq_new;
        vlq_cnt_next = vlq_cnt_inc;
        if (vlq_long) begin
          rec.has_err  = 1'b1;
          rec.err_code = E_LONG_VLQ;
        end else if (!b[7]) begin
          vlq_acc_next  = '0;
          vlq_cnt_next  = '0;
          do_body_start = 1'b1;
          is_sysex      = (phase == PH_XLEN);
        end else begin
          rec.has_err = in_ch.chunk_end;
        end
      end
      PH_BODY: begin
        bytes_rem_next = rem_dec;
        if (body_kind == K_TEMPO || body_kind == K_TIMESIG) begin
          pay_shift_next = shift_in;
          if (rem_dec == '0) begin
            rec.has_res        = 1'b1;
            rec.res.kind       = body_kind;
            rec.res.word_value = shift_in;
          end
        end else begin
          rec.has_res          = 1'b1;
          rec.res.kind         = K_PAYLOAD;
          rec.res.data_first   = b;
          rec.res.payload_last = (rem_dec == '0);
        end
        if (rem_dec == '0) begin
          phase_next = PH_DELTA;
        end else begin
          rec.has_err = in_ch.chunk_end;
        end
      end
      default: begin
        // discard until chunk end
      end
    endcase

    // Length complete: open the body and give the sysex or meta result, or fail on a cut-off body or a bad fixed length
    if (do_body_start) begin
      bytes_rem_next = vlq_new;
      pay_shift_next = '0;
      phase_next     = (vlq_new != '0) ? PH_BODY : PH_DELTA;
      if (vlq_new != '0 && in_ch.chunk_end) begin
        rec.has_err = 1'b1;
      end else if (is_sysex) begin
        rec.has_res            = 1'b1;
        rec.res.kind           = K_SYSEX;
        rec.res.data_first     = cur_status;
        rec.res.word_value     = {4'd0, vlq_new};
      end else if (mk == K_TEMPO && vlq_new != TEMPO_LEN) begin
        rec.has_err  = 1'b1;
        rec.err_code = E_TEMPO_LEN;
      end else if (mk == K_TIMESIG && vlq_new != TIMESIG_LEN) begin
        rec.has_err  = 1'b1;
        rec.err_code = E_TIMESIG_LEN;
      end else if (mk != K_TEMPO && mk != K_TIMESIG) begin
        rec.has_res        = 1'b1;
        rec.res.kind       = mk;
        rec.res.data_first = meta_kind;
        rec.res.word_value = {4'd0, vlq_new};
      end
    end

    // First data byte: one-byte messages complete here
    if (do_data) begin
      if (data_status[7:4] == HI_PROGRAM || data_status[7:4] == HI_CHANPRESS) begin
        emit_ch   = 1'b1;
        ch_status = data_status;
      end else begin
        held_next   = b;
        phase_next  = PH_DATA2;
        rec.has_err = in_ch.chunk_end;
      end
    end

    if (emit_ch) begin
      rec.has_res         = 1'b1;
      rec.res.kind        = kind_t'(ch_status[7:4] - HI_CHAN_BASE);
      rec.res.channel     = ch_status[3:0];
      rec.res.data_first  = ch_d1;
      rec.res.data_second = ch_d2;
      if (ch_status[7:4] == HI_BEND) begin
        bend_raw           = {ch_d2[6:0], ch_d1[6:0]} - BEND_CENTRE;
        rec.res.bend_value = $signed(bend_raw);
      end
      phase_next = PH_DELTA;
    end

    if (rec.has_err) begin
      phase_next = PH_DISCARD;
    end

    rec.tick = tick_ext[31:0];

    // Chunk end restores the reset state
    if (in_ch.chunk_end) begin
      phase_next      = PH_DELTA;
      abs_tick_next   = '0;
      vlq_acc_next    = '0;
      vlq_cnt_next    = '0;
      run_status_next = '0;
      cur_status_next = '0;
      held_next       = '0;
      meta_kind_next  = '0;
      bytes_rem_next  = '0;
      pay_shift_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      abs_tick   <= '0;
      vlq_acc    <= '0;
      vlq_cnt    <= '0;
      run_status <= '0;
      cur_status <= '0;
      held       <= '0;
      meta_kind  <= '0;
      bytes_rem  <= '0;
      pay_shift  <= '0;
    end else if (take) begin
      phase      <= phase_next;
      abs_tick   <= abs_tick_next;
      vlq_acc    <= vlq_acc_next;
      vlq_cnt    <= vlq_cnt_next;
      run_status <= run_status_next;
      cur_status <= cur_status_next;
      held       <= held_next;
      meta_kind  <= meta_kind_next;
      bytes_rem  <= bytes_rem_next;
      pay_shift  <= pay_shift_next;
    end
  end

endmodule

// ----- sv/mtp_queue.sv -----
// Short record queue between the parser front end and the result back end.
module mtp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mtp_pkg::rec_t rec_in,
  input  logic          pop,
  output logic          full,
  output logic          q_valid,
  output mtp_pkg::rec_t rec_out
);
  import mtp_pkg::*;

  rec_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign rec_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ----- sv/mtp_back.sv -----
// Result back end: expands each queued record into one or two result items.
module mtp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mtp_pkg::rec_t rec,
  output logic          pop,
  mtp_out_if.source     out_ch
);
  import mtp_pkg::*;

  logic sub;
  logic show_err;
  logic last;

  assign show_err = sub || !rec.has_res;
  assign last     = sub || !(rec.has_res && rec.has_err);
  assign pop      = q_valid && out_ch.ready && last;

  assign out_ch.valid        = q_valid;
  assign out_ch.tick         = rec.tick;
  assign out_ch.kind         = show_err ? K_ERROR : rec.res.kind;
  assign out_ch.channel      = show_err ? '0 : rec.res.channel;
  assign out_ch.data_first   = show_err ? '0 : rec.res.data_first;
  assign out_ch.data_second  = show_err ? '0 : rec.res.data_second;
  assign out_ch.bend_value   = show_err ? '0 : rec.res.bend_value;
  assign out_ch.word_value   = show_err ? '0 : rec.res.word_value;
  assign out_ch.payload_last = show_err ? 1'b0 : rec.res.payload_last;
  assign out_ch.error_code   = show_err ? rec.err_code : err_t'(0);
  assign out_ch.run_last     = last;

  // Step to the trailing error once the leading result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (q_valid && out_ch.ready) begin
      sub <= !last;
    end
  end

endmodule

// ----- sv/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser: front end, record queue, back end.
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+-----------
//   in_ch    | in  | in_byte, chunk_end                               | valid/ready
//   out_ch   | out | kind, tick, channel, data_first, data_second,    | valid/ready
//            |     | bend_value, word_value, payload_last,            |
//            |     | error_code, run_last                             |
//
// One byte is accepted per cycle while the record queue has room; the whole parse
// step for a byte happens in that cycle in the front end.
// Each byte yields a record of zero, one or two result items; the back end shows one
// item per cycle while the sink is ready, so a byte that gives a result and a truncation
// error shows them as two items in turn. Sustained rate is one byte per cycle while
// each byte gives at most one item and the sink is ready.
// Reset is synchronous and clears parse state and the queue at once; no clearing pass.
// A stalled sink fills the two-entry queue, then ready drops on the input side.
module midi_track_event_parser #(
  parameter int TICK_BITS = mtp_pkg::TICK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mtp_in_if.sink    in_ch,
  mtp_out_if.source out_ch
);
  import mtp_pkg::*;

  logic q_full;
  logic push;
  rec_t rec_in;
  logic pop;
  logic q_valid;
  rec_t rec_out;

  // Parse bytes into records; hold input while the queue is full
  mtp_front #(
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .rec    (rec_in)
  );

  // Decouple parsing from result delivery
  mtp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rec_in  (rec_in),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .rec_out (rec_out)
  );

  // Drain records one result item at a time
  mtp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .rec     (rec_out),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // An error always closes the items of its byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind == K_ERROR) |-> out_ch.run_last)
    else $error("error item not marked as last of its byte");

  // A non-final item is followed by the truncation error at the same tick
  a_err_follows: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.run_last) |=>
      (out_ch.valid && out_ch.kind == K_ERROR && out_ch.error_code == E_TRUNC &&
       out_ch.tick == $past(out_ch.tick)))
    else $error("leading item not followed by truncation error");

  // Payload-last flag only on payload items
  a_plast_kind: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.payload_last) |-> (out_ch.kind == K_PAYLOAD))
    else $error("payload_last on a non-payload item");

  // Front end never writes a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("record pushed into a full queue");
`endif

endmodule
